### src/delta_run_length_encoder_core_defines.svh
// Assertion macros for the delta run-length encoder core.
// No dependencies; included by the top level only.
`ifndef DELTA_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH
`define DELTA_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DRE_ASSERT_IMPLY(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("dre check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DRE_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("dre check failed: next-cycle implication");

`endif

### src/dre_pkg.sv
// Shared types, constants and byte formatting functions of the delta run-length encoder.
// No dependencies; used by dre_front, dre_queue, dre_back and the top level.
`timescale 1ns / 1ps

package dre_pkg;

    localparam logic [16:0] RUN_COUNT_MAX = 17'h1ffff;
    localparam logic [31:0] STEP_LIMIT    = 32'd67;
    localparam logic [31:0] STEP_RUN_MAX  = 32'd7;
    localparam logic [31:0] STEP_BIAS     = 32'd3;

    localparam logic [7:0] TAG_DELTA = 8'h80;
    localparam logic [7:0] TAG_RUN8  = 8'hc0;
    localparam logic [7:0] TAG_RUN16 = 8'he0;
    localparam logic [7:0] TAG_RUN32 = 8'hf0;
    localparam logic [7:0] TAG_END   = 8'hff;

    // Segment order inside one command
    localparam logic [1:0] PH_RUN1 = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_RUN2 = 2'd2;
    localparam logic [1:0] PH_LIT2 = 2'd3;

    typedef enum logic [1:0] {
        MID_NONE,
        MID_BYTE,
        MID_LIT
    } mid_kind_t;

    // One command: everything a single request turns into
    typedef struct packed {
        logic        run1_en;
        logic [16:0] run1_cnt;   // run length minus one
        logic [2:0]  run1_step;
        mid_kind_t   mid_kind;
        logic [7:0]  mid_byte;
        logic [63:0] lit1_val;
        logic        run2_en;
        logic [16:0] run2_cnt;   // run length minus one
        logic [2:0]  run2_step;
        logic        lit2_en;
        logic [63:0] lit2_val;
        logic        wide;       // 8-byte literals
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic [1:0] level;
    } queue_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    function automatic logic [3:0] run_len(input logic [16:0] c);
        logic [3:0] len;
        if (c < 17'd16) begin
            len = 4'd1;
        end else if (c < 17'd256) begin
            len = 4'd2;
        end else if (c < 17'd65536) begin
            len = 4'd3;
        end else begin
            len = 4'd5;
        end
        return len;
    endfunction

    function automatic logic [7:0] run_byte(input logic [16:0] c, input logic [2:0] step,
                                            input logic [3:0] idx);
        logic [7:0] b;
        if (c < 17'd16) begin
            b = {c[4:0], step};
        end else if (c < 17'd256) begin
            b = (idx == 4'd0) ? c[7:0] : (TAG_RUN8 | {5'd0, step});
        end else if (c < 17'd65536) begin
            case (idx)
                4'd0:    b = c[7:0];
                4'd1:    b = c[15:8];
                default: b = TAG_RUN16 | {5'd0, step};
            endcase
        end else begin
            case (idx)
                4'd0:    b = c[7:0];
                4'd1:    b = c[15:8];
                4'd2:    b = {7'd0, c[16]};
                4'd3:    b = 8'd0;
                default: b = TAG_RUN32 | {5'd0, step};
            endcase
        end
        return b;
    endfunction

    function automatic logic [3:0] lit_len(input logic wide);
        return wide ? 4'd9 : 4'd5;
    endfunction

    function automatic logic [7:0] lit_byte(input logic [63:0] val, input logic wide,
                                            input logic [3:0] idx);
        logic [7:0] b;
        if (idx < (wide ? 4'd8 : 4'd4)) begin
            b = val[idx[2:0] * 8 +: 8];
        end else begin
            b = TAG_END;
        end
        return b;
    endfunction

endpackage

### src/dre_front.sv
// Front end of the delta run-length encoder: accepts values, holds line state, builds commands.
// Depends on dre_pkg.
`timescale 1ns / 1ps

module dre_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [63:0]    sample_value,
    input  logic           line_last,
    input  logic           value_mode,
    input  logic           q_full,
    output logic           push,
    output dre_pkg::cmd_t  push_cmd
);

    logic [63:0] prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic [2:0]  run_step_reg, run_step_next;
    logic [16:0] run_count_reg, run_count_next;

    logic        accept;
    logic        present;
    logic        pairable;
    logic [31:0] diff;
    logic [31:0] step_ofs;
    logic        in_range;
    logic        is_run;
    logic [63:0] prev_mid;
    logic        have_prev_mid;
    logic [2:0]  step_mid;
    logic [16:0] count_mid;
    dre_pkg::cmd_t cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        present  = value_mode ? (|sample_value[63:32]) : (|sample_value[31:0]);
        pairable = !value_mode || (prev_reg[31:0] == sample_value[31:0]);
        diff     = value_mode ? (prev_reg[63:32] - sample_value[63:32])
                              : (prev_reg[31:0] - sample_value[31:0]);
        // Biased step wraps so that exactly the steps 0..66 land below the limit
        step_ofs = diff + dre_pkg::STEP_BIAS;
        in_range = step_ofs < dre_pkg::STEP_LIMIT;
        is_run   = step_ofs <= dre_pkg::STEP_RUN_MAX;

        cmd           = '0;
        cmd.mid_kind  = dre_pkg::MID_NONE;
        cmd.run1_cnt  = run_count_reg - 17'd1;
        cmd.run1_step = run_step_reg;
        cmd.lit1_val  = prev_reg;
        cmd.wide      = value_mode;

        prev_mid      = prev_reg;
        have_prev_mid = have_prev_reg;
        step_mid      = run_step_reg;
        count_mid     = run_count_reg;

        if (present) begin
            if (have_prev_reg) begin
                if (pairable && in_range) begin
                    if (is_run) begin
                        if ((run_count_reg != 17'd0) && (run_step_reg == step_ofs[2:0]) &&
                            (run_count_reg != dre_pkg::RUN_COUNT_MAX)) begin
                            count_mid = run_count_reg + 17'd1;
                        end else begin
                            cmd.run1_en = run_count_reg != 17'd0;
                            step_mid    = step_ofs[2:0];
                            count_mid   = 17'd1;
                        end
                    end else begin
                        cmd.run1_en  = run_count_reg != 17'd0;
                        cmd.mid_kind = dre_pkg::MID_BYTE;
                        cmd.mid_byte = dre_pkg::TAG_DELTA | {2'd0, diff[5:0]};
                        step_mid     = 3'd0;
                        count_mid    = 17'd0;
                    end
                end else begin
                    cmd.run1_en  = run_count_reg != 17'd0;
                    cmd.mid_kind = dre_pkg::MID_LIT;
                    step_mid     = 3'd0;
                    count_mid    = 17'd0;
                end
            end
            prev_mid      = sample_value;
            have_prev_mid = 1'b1;
        end

        cmd.run2_cnt  = count_mid - 17'd1;
        cmd.run2_step = step_mid;
        cmd.lit2_val  = prev_mid;

        prev_next      = prev_mid;
        have_prev_next = have_prev_mid;
        run_step_next  = step_mid;
        run_count_next = count_mid;

        if (line_last) begin
            if (have_prev_mid) begin
                cmd.run2_en = count_mid != 17'd0;
                cmd.lit2_en = 1'b1;
            end
            prev_next      = 64'd0;
            have_prev_next = 1'b0;
            run_step_next  = 3'd0;
            run_count_next = 17'd0;
        end
    end

    assign push     = accept && (cmd.run1_en || (cmd.mid_kind != dre_pkg::MID_NONE) ||
                                 cmd.run2_en || cmd.lit2_en);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_reg      <= 64'd0;
            have_prev_reg <= 1'b0;
            run_step_reg  <= 3'd0;
            run_count_reg <= 17'd0;
        end else if (accept) begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            run_step_reg  <= run_step_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

### src/dre_queue.sv
// Two-entry command queue between the front end and the byte sequencer.
// Depends on dre_pkg.
`timescale 1ns / 1ps

module dre_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dre_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output logic                   q_valid,
    output dre_pkg::cmd_t          q_cmd,
    output dre_pkg::queue_status_t status
);

    dre_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;

    assign q_valid      = level_reg != 2'd0;
    assign q_cmd        = entry_reg[rd_ptr_reg];
    assign status.full  = level_reg == 2'd2;
    assign status.level = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/dre_back.sv
// Byte sequencer of the delta run-length encoder: walks one command a byte per cycle
// when out_ready allows. Depends on dre_pkg; holds the core's output register.
`timescale 1ns / 1ps

module dre_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  dre_pkg::cmd_t         q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            code_byte,
    output logic                  burst_last,
    output logic                  line_done,
    output dre_pkg::back_status_t status
);

    dre_pkg::cmd_t cur_reg;
    logic       busy_reg, busy_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] code_byte_reg;
    logic       burst_last_reg;
    logic       line_done_reg;

    logic [3:0] en_cur;
    logic [3:0] en_new;
    logic [3:0] seg_len;
    logic [7:0] seg_byte;
    logic       last_in_seg;
    logic       later_found;
    logic [1:0] later_phase;
    logic [1:0] first_phase;
    logic       cmd_end;
    logic       adv;

    always_comb
    begin
        en_cur = {cur_reg.lit2_en, cur_reg.run2_en,
                  cur_reg.mid_kind != dre_pkg::MID_NONE, cur_reg.run1_en};
        en_new = {q_cmd.lit2_en, q_cmd.run2_en,
                  q_cmd.mid_kind != dre_pkg::MID_NONE, q_cmd.run1_en};

        case (phase_reg)
            dre_pkg::PH_RUN1:
            begin
                seg_len  = dre_pkg::run_len(cur_reg.run1_cnt);
                seg_byte = dre_pkg::run_byte(cur_reg.run1_cnt, cur_reg.run1_step, idx_reg);
            end
            dre_pkg::PH_MID:
            begin
                if (cur_reg.mid_kind == dre_pkg::MID_LIT) begin
                    seg_len  = dre_pkg::lit_len(cur_reg.wide);
                    seg_byte = dre_pkg::lit_byte(cur_reg.lit1_val, cur_reg.wide, idx_reg);
                end else begin
                    seg_len  = 4'd1;
                    seg_byte = cur_reg.mid_byte;
                end
            end
            dre_pkg::PH_RUN2:
            begin
                seg_len  = dre_pkg::run_len(cur_reg.run2_cnt);
                seg_byte = dre_pkg::run_byte(cur_reg.run2_cnt, cur_reg.run2_step, idx_reg);
            end
            default:
            begin
                seg_len  = dre_pkg::lit_len(cur_reg.wide);
                seg_byte = dre_pkg::lit_byte(cur_reg.lit2_val, cur_reg.wide, idx_reg);
            end
        endcase

        last_in_seg = idx_reg == (seg_len - 4'd1);

        // Lowest enabled segment after the current one
        later_found = 1'b0;
        later_phase = phase_reg;
        for (int i = 3; i >= 0; i--) begin
            if (en_cur[i] && (2'(i) > phase_reg)) begin
                later_found = 1'b1;
                later_phase = 2'(i);
            end
        end

        first_phase = dre_pkg::PH_LIT2;
        for (int i = 3; i >= 0; i--) begin
            if (en_new[i]) begin
                first_phase = 2'(i);
            end
        end

        cmd_end = last_in_seg && !later_found;
        adv     = busy_reg && (!out_valid_reg || out_ready);
        q_pop   = q_valid && (!busy_reg || (adv && cmd_end));

        out_valid_next = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (q_pop) begin
            busy_next  = 1'b1;
            phase_next = first_phase;
            idx_next   = 4'd0;
        end else if (adv) begin
            if (cmd_end) begin
                busy_next = 1'b0;
            end else if (last_in_seg) begin
                phase_next = later_phase;
                idx_next   = 4'd0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            phase_reg     <= dre_pkg::PH_RUN1;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
        if (adv) begin
            code_byte_reg  <= seg_byte;
            burst_last_reg <= cmd_end;
            line_done_reg  <= cmd_end && cur_reg.lit2_en;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_byte   = code_byte_reg;
    assign burst_last  = burst_last_reg;
    assign line_done   = line_done_reg;
    assign status.busy = busy_reg;

endmodule

### src/delta_run_length_encoder_core.sv
// Delta run-length encoder core. Takes one line of values, one request per cycle on the input
// channel, and returns the compressed line as a byte stream. A value is present when it is
// nonzero (value_mode 0: low 32 bits, 4-byte literals) or its high half is nonzero
// (value_mode 1: 8-byte literals, pairs also need equal low halves). Step = previous - current
// + 3; steps 0..7 gather into runs, 8..66 give one delta byte, anything else gives a literal
// of the previous value plus 0xff. line_last closes the line with a run flush and a final
// literal; burst_last marks the last byte of each input request and line_done the final 0xff
// of the line. Rate: the front end accepts one request every cycle while its two-entry command
// queue has room; the byte sequencer puts out one byte per cycle while out_ready does not stall
// it, and takes the next command as it puts out the last byte of the current one. A request
// yields 0 to 23 bytes. An accepted request is written into the queue at the accepting edge,
// then the sequencer loads it and the output register takes its first byte. The user must
// write value_mode only while the core is idle; the core itself does not enforce it.
`timescale 1ns / 1ps
`include "delta_run_length_encoder_core_defines.svh"

module delta_run_length_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] sample_value,
    input  logic        line_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic        burst_last,
    output logic        line_done,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data
);

    // Configuration: mode of the values on the line
    logic value_mode_reg;

    // Front end to queue
    logic          push;
    dre_pkg::cmd_t push_cmd;

    // Queue to sequencer
    logic                   q_valid;
    logic                   q_pop;
    dre_pkg::cmd_t          q_cmd;
    dre_pkg::queue_status_t q_status;
    dre_pkg::back_status_t  back_status;

    // Hold the mode register; the user must write it only between lines, the core does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            value_mode_reg <= 1'b0;
        end else if (cfg_write_en) begin
            value_mode_reg <= cfg_write_data;
        end
    end

    // Classify each value against the line state and turn it into at most one command
    dre_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .line_last    (line_last),
        .value_mode   (value_mode_reg),
        .q_full       (q_status.full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // Decouple the front end from bursts on the byte side
    dre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .status   (q_status)
    );

    // Advance through the command's segments, one byte per free output slot
    dre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_byte  (code_byte),
        .burst_last (burst_last),
        .line_done  (line_done),
        .status     (back_status)
    );

    // The line's final byte always closes a request's burst
    `DRE_ASSERT_IMPLY(a_line_done_ends_burst, out_valid && line_done, burst_last)
    // The queue never holds more than its two entries
    `DRE_ASSERT_IMPLY(a_queue_bounded, 1'b1, q_status.level != 2'd3)
    // An idle sequencer picks up waiting work in the next cycle
    `DRE_ASSERT_NEXT(a_back_picks_up, q_valid && !back_status.busy, back_status.busy)

endmodule

### verif/delta_run_length_encoder_core_tb.sv
// Self-checking testbench for delta_run_length_encoder_core: queued line values and an
// in-bench byte predictor checked against the output stream under random idling.
// Depends on dre_pkg (tag constants, run counter and step limits) and the core RTL.
`timescale 1ns / 1ps

module delta_run_length_encoder_core_tb;

    localparam int  SETTLE_CYCLES   = 16;         // well past the core latency
    localparam int  MID_RUN_VALUES  = 20;         // run long enough for the one-byte count form
    localparam int  REPORT_LIMIT    = 10;
    localparam time RUN_LIMIT_NS    = 20_000_000;

    // One line value as the sender presents it
    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } sample_req_t;

    // One output byte with its side flags
    typedef struct packed {
        logic [7:0] code;
        logic       burst;
        logic       done;
    } code_rec_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [63:0] sample_value   = '0;
    logic        line_last      = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [7:0]  code_byte;
    logic        burst_last;
    logic        line_done;
    logic        cfg_write_en   = 1'b0;
    logic        cfg_write_data = 1'b0;

    sample_req_t pending_samples[$];   // values waiting to be offered to the core
    code_rec_t   expected_codes[$];    // bytes predicted but not yet seen
    code_rec_t   burst_codes[$];       // bytes of the request being predicted
    code_rec_t   want_code;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned queued_count   = 0;

    // Predictor copy of the encoder state and its one register
    logic        enc_mode    = 1'b0;
    logic [63:0] prior_value = '0;
    logic        have_prior  = 1'b0;
    logic [2:0]  open_step   = '0;
    logic [16:0] open_count  = '0;

    delta_run_length_encoder_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .line_last      (line_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .code_byte      (code_byte),
        .burst_last     (burst_last),
        .line_done      (line_done),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Byte predictor
    // ------------------------------------------------------------------

    function automatic void emit_byte(input logic [7:0] b);
        code_rec_t rec;
        rec.code  = b;
        rec.burst = 1'b0;
        rec.done  = 1'b0;
        burst_codes.push_back(rec);
    endfunction

    // Close the open run: short runs pack count and step into one byte, longer ones
    // put the count little-endian ahead of a tag that carries the step.
    function automatic void flush_open_run();
        logic [16:0] cnt;
        if (open_count == 0)
            return;
        cnt = open_count - 17'd1;
        if (cnt < 17'd16) begin
            emit_byte({cnt[4:0], open_step});
        end else if (cnt < 17'd256) begin
            emit_byte(cnt[7:0]);
            emit_byte(dre_pkg::TAG_RUN8 | {5'd0, open_step});
        end else if (cnt < 17'd65536) begin
            emit_byte(cnt[7:0]);
            emit_byte(cnt[15:8]);
            emit_byte(dre_pkg::TAG_RUN16 | {5'd0, open_step});
        end else begin
            emit_byte(cnt[7:0]);
            emit_byte(cnt[15:8]);
            emit_byte({7'd0, cnt[16]});
            emit_byte(8'h00);
            emit_byte(dre_pkg::TAG_RUN32 | {5'd0, open_step});
        end
        open_count = '0;
        open_step  = '0;
    endfunction

    // Literal of the held value, width set by the mode in force right now
    function automatic void emit_literal(input logic [63:0] v);
        int nbytes;
        nbytes = enc_mode ? 8 : 4;
        for (int i = 0; i < nbytes; i++)
            emit_byte(v[8*i +: 8]);
        emit_byte(dre_pkg::TAG_END);
    endfunction

    function automatic void predict_codes(input logic [63:0] value, input logic last);
        logic        present;
        logic        pairable;
        logic [31:0] diff;
        longint      step;
        code_rec_t   rec;
        burst_codes.delete();
        present = enc_mode ? (value[63:32] != '0) : (value[31:0] != '0);
        if (present) begin
            if (have_prior) begin
                if (enc_mode) begin
                    pairable = (prior_value[31:0] == value[31:0]);
                    diff     = prior_value[63:32] - value[63:32];
                end else begin
                    pairable = 1'b1;
                    diff     = prior_value[31:0] - value[31:0];
                end
                // the 32-bit difference is two's complement; no overflow in 64 bits
                step = longint'(signed'(diff)) + 64'sd3;
                if (pairable && step >= 0 && step < longint'(dre_pkg::STEP_LIMIT)) begin
                    if (step <= longint'(dre_pkg::STEP_RUN_MAX)) begin
                        if (open_count != 0 && open_step == 3'(step)
                                && open_count < dre_pkg::RUN_COUNT_MAX) begin
                            open_count = open_count + 17'd1;
                        end else begin
                            flush_open_run();
                            open_step  = 3'(step);
                            open_count = 17'd1;
                        end
                    end else begin
                        flush_open_run();
                        emit_byte(dre_pkg::TAG_DELTA | 8'(step - 3));
                    end
                end else begin
                    flush_open_run();
                    emit_literal(prior_value);
                end
            end
            prior_value = value;
            have_prior  = 1'b1;
        end
        if (last) begin
            if (have_prior) begin
                flush_open_run();
                emit_literal(prior_value);
                rec = burst_codes.pop_back();
                rec.done = 1'b1;
                burst_codes.push_back(rec);
            end
            have_prior  = 1'b0;
            prior_value = '0;
            open_count  = '0;
            open_step   = '0;
        end
        if (burst_codes.size() != 0) begin
            rec = burst_codes.pop_back();
            rec.burst = 1'b1;
            burst_codes.push_back(rec);
        end
        foreach (burst_codes[i])
            expected_codes.push_back(burst_codes[i]);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued values, predict each accepted request
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            sample_value <= '0;
            line_last    <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_codes(pending_samples[0].value, pending_samples[0].last);
                pending_samples.delete(0);
            end
            // hold the request while it is not taken; otherwise pick the next one or idle
            if (!in_valid || in_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid     <= 1'b1;
                    sample_value <= pending_samples[0].value;
                    line_last    <= pending_samples[0].last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, check every accepted byte
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string what, input code_rec_t want);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %02h %b %b, got %02h %b %b (byte burst_last line_done)",
                     $time, what, want.code, want.burst, want.done,
                     code_byte, burst_last, line_done);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("byte with nothing expected", '0);
                end else begin
                    want_code = expected_codes.pop_front();
                    if (want_code.code !== code_byte || want_code.burst !== burst_last
                            || want_code.done !== line_done)
                        report_mismatch("byte mismatch", want_code);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_sample(input logic [63:0] value, input logic last);
        sample_req_t req;
        req.value = value;
        req.last  = last;
        pending_samples.push_back(req);
        queued_count++;
    endfunction

    // Build a value from the half that carries the step and the other half:
    // mode 1 keeps the low half fixed so pairs stay pairable, mode 0 fills the
    // ignored high half with noise.
    function automatic logic [63:0] compose_value(input logic [31:0] key, input logic [31:0] tag);
        return enc_mode ? {key, tag} : {32'($urandom), key};
    endfunction

    function automatic logic [63:0] absent_value();
        return enc_mode ? {32'd0, 32'($urandom)} : {32'($urandom), 32'd0};
    endfunction

    // Well-formed line: mostly runs and delta bytes, some literals, absent values
    // and steps just outside the delta range. The last value closes the line.
    task automatic add_random_line(input int n_items);
        logic [31:0] key;
        logic [31:0] tag;
        logic [63:0] vals[$];
        int          kind;
        int          step;
        int          seg_len;
        key = $urandom;
        tag = $urandom;
        if (key == '0)
            key = 32'd1;
        vals.push_back(compose_value(key, tag));
        while (vals.size() < n_items) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                step    = $urandom_range(7);
                seg_len = ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 6);
                repeat (seg_len)
                begin
                    key = key - 32'(step - 3);
                    vals.push_back(compose_value(key, tag));
                end
            end else if (kind < 65) begin
                step = $urandom_range(8, 66);
                key  = key - 32'(step - 3);
                vals.push_back(compose_value(key, tag));
            end else if (kind < 80) begin
                if (enc_mode && $urandom_range(1) == 0)
                    tag = $urandom;
                else
                    key = $urandom;
                vals.push_back(compose_value(key, tag));
            end else if (kind < 90) begin
                vals.push_back(absent_value());
            end else begin
                step = ($urandom_range(1) == 0) ? -1 - int'($urandom_range(5))
                                                : 67 + int'($urandom_range(5));
                key  = key - 32'(step - 3);
                vals.push_back(compose_value(key, tag));
            end
        end
        foreach (vals[i])
            push_sample(vals[i], i == vals.size() - 1);
    endtask

    // Unstructured values: whole random words, some with a zero half
    task automatic add_noise(input int n_items);
        logic [63:0] v;
        repeat (n_items)
        begin
            v = {32'($urandom), 32'($urandom)};
            case ($urandom_range(3))
                0:       v[31:0]  = '0;
                1:       v[63:32] = '0;
                default: ;
            endcase
            push_sample(v, $urandom_range(3) == 0);
        end
    endtask

    // Write the mode while the core is idle and update the predictor's copy of it
    task automatic write_value_mode(input logic mode);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= mode;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        enc_mode = mode;
    endtask

    // Wait until every request is taken and every byte seen, then let any
    // request that makes no bytes clear the pipeline.
    task automatic drain_and_settle();
        while (pending_samples.size() != 0 || in_valid || expected_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned first_count;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, mode 0, no idling
        write_value_mode(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // all-zero line, ended by an absent value with a busy high half
        push_sample(64'h0, 1'b0);
        push_sample(64'hffffffff_00000000, 1'b1);
        // delta range edges, literals on both sides of it, runs at step 0 and 7,
        // and steps whose 32-bit difference wraps
        push_sample(64'd1000, 1'b0);
        push_sample(64'd995, 1'b0);          // lowest delta step
        push_sample(64'd932, 1'b0);          // highest delta step
        push_sample(64'd868, 1'b0);          // one past the delta range
        push_sample(64'd872, 1'b0);          // negative step
        push_sample(64'd875, 1'b0);          // run at step 0
        push_sample(64'd878, 1'b0);
        push_sample(64'd874, 1'b0);          // run at step 7
        push_sample(64'd0, 1'b0);            // absent, skipped
        push_sample(64'd1, 1'b0);
        push_sample(64'h00000000_ffffffff, 1'b0);
        push_sample(64'h00000000_80000000, 1'b0);
        push_sample(64'h00000000_7fffffff, 1'b0);
        push_sample(64'h00000000_80000000, 1'b1);
        // open a line that the next mode carries on
        push_sample(64'h00000005_00000007, 1'b0);
        drain_and_settle();

        // Directed, mode 1, same line continues under the new mode
        write_value_mode(1'b1);
        push_sample(64'h00000005_00000007, 1'b0);
        push_sample(64'h00000002_00000007, 1'b0);
        push_sample(64'h00000002_00000008, 1'b0);    // low halves differ
        push_sample(64'h80000000_00000008, 1'b0);
        push_sample(64'h7fffffff_00000008, 1'b0);
        push_sample(64'h00000000_12345678, 1'b0);    // absent in this mode
        push_sample(64'hffffffff_ffffffff, 1'b0);
        push_sample(64'h0, 1'b1);                    // absent value still ends the line
        push_sample(64'h00000009_00000003, 1'b0);
        drain_and_settle();

        // Back to mode 0 mid-line, then a run long enough for a count byte and tag
        write_value_mode(1'b0);
        push_sample(64'h00000009_00000006, 1'b0);
        push_sample(64'h00000000_00000001, 1'b1);
        repeat (MID_RUN_VALUES - 1) push_sample(64'd77, 1'b0);
        push_sample(64'd77, 1'b1);
        drain_and_settle();

        // Random lines under each idling mix, alternating the mode
        for (int ph = 0; ph < 4; ph++) begin
            write_value_mode(ph % 2 == 0);
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            first_count = queued_count;
            while (queued_count - first_count < 18)
                add_random_line($urandom_range(2, 12));
            // noise may leave a line open across the next mode write
            add_noise(6);
            drain_and_settle();
        end

        if (error_count == 0 && expected_codes.size() == 0)
            $display("delta_run_length_encoder_core_tb: PASS");
        else
            $display("delta_run_length_encoder_core_tb: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("delta_run_length_encoder_core_tb: FAIL");
        $finish;
    end

endmodule
